// ----- rtl/cc20_pkg.sv -----
// Shared types, constants and helper functions for the ChaCha20 stream cipher core.
package cc20_pkg;

	localparam int ROUND_COUNT = 20;
	localparam int RND_W = $clog2(ROUND_COUNT);
	localparam int LANES = 4;

	typedef logic [15:0][31:0] blk_t;
	typedef logic [7:0][63:0] ks_t;

	typedef struct packed {
		logic [63:0] msg_data;
		logic [3:0] byte_count;
		logic end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [63:0] out_data;
		logic [3:0] out_byte_count;
		logic out_last;
	} res_item_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} qr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

	typedef enum logic [2:0] {
		REG_KEY_0_7 = 3'd0,
		REG_KEY_8_15 = 3'd1,
		REG_KEY_16_23 = 3'd2,
		REG_KEY_24_31 = 3'd3,
		REG_LONG_KEY = 3'd4,
		REG_NONCE = 3'd5,
		REG_START_CTR = 3'd6
	} cfg_reg_t;

	localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32,
		32'h6b206574};
	localparam logic [31:0] TAU [4] = '{32'h61707865, 32'h3120646e, 32'h79622d36,
		32'h6b206574};

	// Word indices a, b, c, d of each lane: first the column round, then the diagonal round.
	localparam logic [3:0] QR_IDX [2][4][4] = '{
		'{'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
		  '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15}},
		'{'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
		  '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}}
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ----- rtl/cc20_qr_lane.sv -----
// One ChaCha20 quarter-round lane acting on four 32-bit state words.
module cc20_qr_lane (
	input  cc20_pkg::qr_t qi,
	output cc20_pkg::qr_t qo
);

	always_comb begin
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		a = qi.a;
		b = qi.b;
		c = qi.c;
		d = qi.d;
		a = a + b;
		d = cc20_pkg::rotl(d ^ a, 16);
		c = c + d;
		b = cc20_pkg::rotl(b ^ c, 12);
		a = a + b;
		d = cc20_pkg::rotl(d ^ a, 8);
		c = c + d;
		b = cc20_pkg::rotl(b ^ c, 7);
		qo.a = a;
		qo.b = b;
		qo.c = c;
		qo.d = d;
	end

endmodule

// ----- rtl/cc20_block_gen.sv -----
// Keystream block generator: four quarter-round lanes per round and a feed-forward merge.
module cc20_block_gen (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cc20_pkg::blk_t init,
	output cc20_pkg::gen_stat_t stat,
	output cc20_pkg::ks_t ks
);

	typedef enum logic [2:0] {
		G_IDLE = 3'b001,
		G_ROUND = 3'b010,
		G_MERGE = 3'b100
	} gen_state_t;

	localparam logic [cc20_pkg::RND_W-1:0] LAST_RND = cc20_pkg::RND_W'(cc20_pkg::ROUND_COUNT - 1);

	gen_state_t state_q;
	logic [cc20_pkg::RND_W-1:0] round_q;
	cc20_pkg::blk_t st_q;
	cc20_pkg::blk_t init_q;
	cc20_pkg::blk_t st_d;
	cc20_pkg::qr_t qi [cc20_pkg::LANES];
	cc20_pkg::qr_t qo [cc20_pkg::LANES];
	logic diag;

	assign diag = round_q[0];

	for (genvar l = 0; l < cc20_pkg::LANES; l++) begin : g_lane
		always_comb begin
			qi[l].a = st_q[cc20_pkg::QR_IDX[diag][l][0]];
			qi[l].b = st_q[cc20_pkg::QR_IDX[diag][l][1]];
			qi[l].c = st_q[cc20_pkg::QR_IDX[diag][l][2]];
			qi[l].d = st_q[cc20_pkg::QR_IDX[diag][l][3]];
		end

		cc20_qr_lane u_lane (
			.qi(qi[l]),
			.qo(qo[l])
		);
	end

	always_comb begin
		st_d = st_q;
		for (int l = 0; l < cc20_pkg::LANES; l++) begin
			st_d[cc20_pkg::QR_IDX[diag][l][0]] = qo[l].a;
			st_d[cc20_pkg::QR_IDX[diag][l][1]] = qo[l].b;
			st_d[cc20_pkg::QR_IDX[diag][l][2]] = qo[l].c;
			st_d[cc20_pkg::QR_IDX[diag][l][3]] = qo[l].d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			round_q <= '0;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						state_q <= G_ROUND;
						round_q <= '0;
					end
				end
				G_ROUND: begin
					if (round_q == LAST_RND) begin
						state_q <= G_MERGE;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				G_MERGE: begin
					state_q <= G_IDLE;
				end
				default: begin
					state_q <= G_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == G_IDLE && start) begin
			st_q <= init;
			init_q <= init;
		end else if (state_q == G_ROUND) begin
			st_q <= st_d;
		end
	end

	// The merge adds the input block back onto the final working state.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ks[i] = {st_q[2 * i + 1] + init_q[2 * i + 1], st_q[2 * i] + init_q[2 * i]};
		end
	end

	assign stat.busy = (state_q != G_IDLE);
	assign stat.done = (state_q == G_MERGE);

endmodule

// ----- rtl/chacha20_stream_cipher_core.sv -----
// ChaCha20 stream cipher core: configuration, block counter, keystream store and message XOR.
//
// Channel  Direction  Handshake             Payload
// msg      in         msg_valid/msg_stall   cc20_pkg::msg_item_t
// res      out        res_valid/res_stall   cc20_pkg::res_item_t
// cfg      in         cfg_write             cfg_index, cfg_data
//
// An item whose word position is not zero has its result registered once the output register is free.
// An item at word position zero first waits for a new block: the generator is started, runs 20
// rounds of the four-lane round unit and then merges the input block back in.
// Reset zeroes keys, nonce, counters, word position and valid flags, and selects the long key.
// A stalled result holds in the output register while one further transaction is taken.
module chacha20_stream_cipher_core (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  cc20_pkg::msg_item_t msg,
	output logic res_valid,
	input  logic res_stall,
	output cc20_pkg::res_item_t res,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key0_q;
	logic [63:0] key1_q;
	logic [63:0] key2_q;
	logic [63:0] key3_q;
	logic long_q;
	logic [63:0] nonce_q;
	logic [63:0] start_q;
	logic [63:0] ctr_q;
	logic [2:0] pos_q;
	logic fresh_q;
	logic pend_q;
	cc20_pkg::msg_item_t item_q;
	logic [63:0] ks_q [8];
	logic res_valid_q;
	cc20_pkg::res_item_t res_q;

	cc20_pkg::blk_t init;
	cc20_pkg::ks_t ks;
	cc20_pkg::gen_stat_t gstat;
	logic gen_start;
	logic fire;
	logic nonce_wr;
	logic [3:0] cnt;
	logic [63:0] mask;
	logic [63:0] hi0;
	logic [63:0] hi1;

	assign nonce_wr = cfg_write && (cfg_index == cc20_pkg::REG_NONCE);
	assign fire = pend_q && (pos_q != 3'd0 || fresh_q) && (!res_valid_q || !res_stall);
	assign gen_start = pend_q && (pos_q == 3'd0) && !fresh_q && !gstat.busy;
	assign msg_stall = pend_q && !fire;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		hi0 = long_q ? key2_q : key0_q;
		hi1 = long_q ? key3_q : key1_q;
		for (int i = 0; i < 4; i++) begin
			init[i] = long_q ? cc20_pkg::SIGMA[i] : cc20_pkg::TAU[i];
		end
		init[4] = key0_q[31:0];
		init[5] = key0_q[63:32];
		init[6] = key1_q[31:0];
		init[7] = key1_q[63:32];
		init[8] = hi0[31:0];
		init[9] = hi0[63:32];
		init[10] = hi1[31:0];
		init[11] = hi1[63:32];
		init[12] = ctr_q[31:0];
		init[13] = ctr_q[63:32];
		init[14] = nonce_q[31:0];
		init[15] = nonce_q[63:32];
	end

	cc20_block_gen u_gen (
		.clk(clk),
		.arst_n(arst_n),
		.start(gen_start),
		.init(init),
		.stat(gstat),
		.ks(ks)
	);

	always_comb begin
		cnt = (item_q.byte_count > 4'd8) ? 4'd8 : item_q.byte_count;
		for (int i = 0; i < 8; i++) begin
			mask[8 * i +: 8] = (cnt > 4'(i)) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			long_q <= 1'b1;
			nonce_q <= '0;
			start_q <= '0;
		end else if (cfg_write) begin
			unique case (cc20_pkg::cfg_reg_t'(cfg_index))
				cc20_pkg::REG_KEY_0_7: key0_q <= cfg_data;
				cc20_pkg::REG_KEY_8_15: key1_q <= cfg_data;
				cc20_pkg::REG_KEY_16_23: key2_q <= cfg_data;
				cc20_pkg::REG_KEY_24_31: key3_q <= cfg_data;
				cc20_pkg::REG_LONG_KEY: long_q <= cfg_data[0];
				cc20_pkg::REG_NONCE: nonce_q <= cfg_data;
				cc20_pkg::REG_START_CTR: start_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			pos_q <= '0;
			fresh_q <= 1'b0;
		end else if (nonce_wr) begin
			ctr_q <= start_q;
			pos_q <= '0;
			fresh_q <= 1'b0;
		end else begin
			if (gen_start) begin
				ctr_q <= ctr_q + 64'd1;
			end
			if (gstat.done) begin
				fresh_q <= 1'b1;
			end
			if (fire) begin
				fresh_q <= 1'b0;
				pos_q <= item_q.end_of_message ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (msg_valid && !msg_stall) begin
				pend_q <= 1'b1;
			end else if (fire) begin
				pend_q <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg_valid && !msg_stall) begin
			item_q <= msg;
		end
		if (gstat.done) begin
			for (int i = 0; i < 8; i++) begin
				ks_q[i] <= ks[i];
			end
		end
		if (fire) begin
			res_q.out_data <= (item_q.msg_data ^ ks_q[pos_q]) & mask;
			res_q.out_byte_count <= cnt;
			res_q.out_last <= item_q.end_of_message;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		gen_start |-> !gstat.busy)
		else $error("A block was started while the generator was busy.");

	a_fire_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> pend_q)
		else $error("A result was loaded without a pending transaction.");

	a_fresh_pos: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> (pos_q == 3'd0))
		else $error("A fresh block is marked away from the start of the block.");

	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		gstat.done |-> (pos_q == 3'd0) && !fresh_q)
		else $error("A block finished while the keystream was still in use.");

endmodule
